### rtl/core/htfd_pkg.sv
package htfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int TEMP_W    = 15;
    localparam int HUM_W     = 14;
    localparam int STATUS_W  = 2;
    localparam int PROD_W    = 31;
    localparam int QUOT_W    = 15;
    localparam int CFG_IDX_W = 1;

    localparam int FIFO_DEPTH_DEFAULT = 2;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

    // Scale factors in hundredths: span 175.0 and 100.0, offset -45.0
    localparam logic [PROD_W-1:0] TEMP_SPAN    = 31'd17500;
    localparam logic [PROD_W-1:0] HUM_SPAN     = 31'd10000;
    localparam logic [QUOT_W-1:0] TEMP_OFFSET  = 15'd4500;
    localparam logic [QUOT_W-1:0] HUM_MAX      = 15'd10000;

    localparam logic signed [TEMP_W-1:0] TEMP_LOW_RESET  = -15'sd4000;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RESET = 15'sd12500;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH = 1'b1;

    typedef enum logic [2:0] {
        POS_TEMP_MSB,
        POS_TEMP_LSB,
        POS_TEMP_CRC,
        POS_HUM_MSB,
        POS_HUM_LSB,
        POS_HUM_CRC
    } byte_pos_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK,
        STATUS_TEMP_CRC,
        STATUS_HUM_CRC,
        STATUS_RANGE
    } status_t;

    // One captured frame handed from the front end to the back end
    typedef struct packed {
        logic [WORD_W-1:0] temp_word;
        logic [WORD_W-1:0] hum_word;
        logic              temp_crc_bad;
        logic              hum_crc_bad;
    } frame_t;

    // Packed so that temp lands in the lowest bits
    typedef struct packed {
        status_t                    status;
        logic [HUM_W-1:0]           hum;
        logic signed [TEMP_W-1:0]   temp;
    } result_t;

    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_W; i++)
        begin
            c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // floor(x / 65535): take x >> 16, then one correction step.
    // Remainder estimate is below twice the divisor for x < 2^31.
    function automatic logic [QUOT_W-1:0] div_word_max(input logic [PROD_W-1:0] x);
        logic [QUOT_W-1:0] q0;
        logic [WORD_W:0]   r;
        q0 = x[PROD_W-1:WORD_W];
        r  = {1'b0, x[WORD_W-1:0]} + {{(WORD_W+1-QUOT_W){1'b0}}, q0};
        if (r >= 17'd65535)
        begin
            q0 = q0 + 1'b1;
        end
        return q0;
    endfunction

endpackage

### rtl/core/htfd_front.sv
module htfd_front
    import htfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              frame_start,
    input  logic              queue_full,
    output logic              push,
    output frame_t            frame
);

    byte_pos_t         pos_reg, pos_next, pos_eff;
    logic [BYTE_W-1:0] crc_reg, crc_next, crc_in, crc_upd;
    logic [WORD_W-1:0] temp_word_reg, temp_word_next;
    logic [WORD_W-1:0] hum_word_reg, hum_word_next;
    logic              temp_bad_reg, temp_bad_next;
    logic              accept;

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;

    // Frame start forces byte zero and a fresh CRC
    assign pos_eff = frame_start ? POS_TEMP_MSB : pos_reg;
    assign crc_in  = frame_start ? CRC_INIT : crc_reg;
    assign crc_upd = crc8_byte(crc_in, rx_byte);

    // Next byte position
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            unique case (pos_eff)
                POS_TEMP_MSB: pos_next = POS_TEMP_LSB;
                POS_TEMP_LSB: pos_next = POS_TEMP_CRC;
                POS_TEMP_CRC: pos_next = POS_HUM_MSB;
                POS_HUM_MSB:  pos_next = POS_HUM_LSB;
                POS_HUM_LSB:  pos_next = POS_HUM_CRC;
                default:      pos_next = POS_TEMP_MSB;
            endcase
        end
    end

    // Datapath updates per byte position
    always_comb
    begin
        crc_next       = crc_reg;
        temp_word_next = temp_word_reg;
        hum_word_next  = hum_word_reg;
        temp_bad_next  = temp_bad_reg;
        push           = 1'b0;
        if (accept)
        begin
            unique case (pos_eff)
                POS_TEMP_MSB:
                begin
                    temp_word_next = {rx_byte, temp_word_reg[BYTE_W-1:0]};
                    crc_next       = crc_upd;
                end
                POS_TEMP_LSB:
                begin
                    temp_word_next = {temp_word_reg[WORD_W-1:BYTE_W], rx_byte};
                    crc_next       = crc_upd;
                end
                POS_TEMP_CRC:
                begin
                    temp_bad_next = (rx_byte != crc_in);
                    crc_next      = CRC_INIT;
                end
                POS_HUM_MSB:
                begin
                    hum_word_next = {rx_byte, hum_word_reg[BYTE_W-1:0]};
                    crc_next      = crc_upd;
                end
                POS_HUM_LSB:
                begin
                    hum_word_next = {hum_word_reg[WORD_W-1:BYTE_W], rx_byte};
                    crc_next      = crc_upd;
                end
                default:
                begin
                    crc_next      = CRC_INIT;
                    temp_bad_next = 1'b0;
                    push          = 1'b1;
                end
            endcase
        end
    end

    assign frame.temp_word    = temp_word_reg;
    assign frame.hum_word     = hum_word_reg;
    assign frame.temp_crc_bad = temp_bad_reg;
    assign frame.hum_crc_bad  = (rx_byte != crc_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_TEMP_MSB;
            crc_reg      <= CRC_INIT;
            temp_bad_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            temp_bad_reg <= temp_bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        temp_word_reg <= temp_word_next;
        hum_word_reg  <= hum_word_next;
    end

endmodule

### rtl/core/htfd_fifo.sv
module htfd_fifo
    import htfd_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t push_data,
    output logic   full,
    input  logic   pop,
    output frame_t pop_data,
    output logic   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    frame_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/htfd_back.sv
module htfd_back
    import htfd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  frame_t                   in_frame,
    input  logic signed [TEMP_W-1:0] temp_low,
    input  logic signed [TEMP_W-1:0] temp_high,
    output logic                     out_valid,
    input  logic                     out_ready,
    output result_t                  out_result
);

    // Stage 1: products
    logic              v1_reg;
    logic [PROD_W-1:0] temp_prod_reg, hum_prod_reg;
    logic              temp_bad1_reg, hum_bad1_reg;
    // Stage 2: quotients
    logic                     v2_reg;
    logic signed [TEMP_W-1:0] temp2_reg;
    logic [HUM_W-1:0]         hum2_reg;
    logic                     temp_bad2_reg, hum_bad2_reg;
    // Stage 3: result register
    logic    v3_reg;
    result_t res3_reg;

    logic              s1_ready, s2_ready, s3_ready;
    logic              load1, load2, load3;
    logic [QUOT_W-1:0] temp_q, hum_q, hum_clamped;
    logic              out_of_range;
    status_t           status_next;

    assign s3_ready = !v3_reg || out_ready;
    assign s2_ready = !v2_reg || s3_ready;
    assign s1_ready = !v1_reg || s2_ready;
    assign in_ready = s1_ready;

    assign load1 = in_valid && s1_ready;
    assign load2 = v1_reg && s2_ready;
    assign load3 = v2_reg && s3_ready;

    assign temp_q      = div_word_max(temp_prod_reg);
    assign hum_q       = div_word_max(hum_prod_reg);
    assign hum_clamped = (hum_q > HUM_MAX) ? HUM_MAX : hum_q;

    assign out_of_range = (temp2_reg < temp_low) || (temp2_reg > temp_high);

    always_comb
    begin
        priority if (temp_bad2_reg)
        begin
            status_next = STATUS_TEMP_CRC;
        end
        else if (hum_bad2_reg)
        begin
            status_next = STATUS_HUM_CRC;
        end
        else if (out_of_range)
        begin
            status_next = STATUS_RANGE;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                v1_reg <= in_valid;
            end
            if (s2_ready)
            begin
                v2_reg <= v1_reg;
            end
            if (s3_ready)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            temp_prod_reg <= TEMP_SPAN * PROD_W'(in_frame.temp_word);
            hum_prod_reg  <= HUM_SPAN * PROD_W'(in_frame.hum_word);
            temp_bad1_reg <= in_frame.temp_crc_bad;
            hum_bad1_reg  <= in_frame.hum_crc_bad;
        end
        if (load2)
        begin
            temp2_reg     <= $signed(temp_q - TEMP_OFFSET);
            hum2_reg      <= hum_clamped[HUM_W-1:0];
            temp_bad2_reg <= temp_bad1_reg;
            hum_bad2_reg  <= hum_bad1_reg;
        end
        if (load3)
        begin
            res3_reg.temp   <= temp2_reg;
            res3_reg.hum    <= hum2_reg;
            res3_reg.status <= status_next;
        end
    end

    assign out_valid  = v3_reg;
    assign out_result = res3_reg;

endmodule

### rtl/core/humidity_temp_frame_decoder.sv
// Measurement frame decoder for a temperature/humidity sensor. Feed the six
// frame bytes one per beat in wire order (temperature MSB, LSB, CRC, humidity
// MSB, LSB, CRC); set s_tuser on the first byte to resync the byte count. Each
// word is checked with CRC-8 (poly 0x31, init 0xFF). After the sixth byte one
// result beat carries temperature in centidegrees, humidity in centipercent
// and a status code: temperature CRC bad, then humidity CRC bad, then
// temperature outside the programmed limits, first failure wins. Rate: one
// byte per clock while s_tready is high, so one result per six bytes. The
// front end updates CRC and byte count as each byte is accepted; completed
// frames go through a FIFO_DEPTH-entry queue into a three-stage conversion
// pipe (multiply, divide-by-65535 correction, limit check); m_tvalid rises
// once a frame has passed the queue and the product, quotient and result
// registers. s_tready drops only while the queue is full, i.e. when the
// result side has been stalled for several frames. Write the limit registers
// through cfg_we/cfg_index/cfg_wdata while idle.
module humidity_temp_frame_decoder
    import htfd_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input byte stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  logic                 s_tuser,   // [0] frame_start
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [14:0] temp_centideg,
                                            // [28:15] humidity_centipct,
                                            // [30:29] frame_status, [31] zero
    // limit registers
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TEMP_W-1:0]    cfg_wdata
);

    logic signed [TEMP_W-1:0] temp_low_reg, temp_high_reg;

    logic    push, queue_full, queue_empty, pop;
    frame_t  push_frame, pop_frame;
    result_t result;

    // Capture limit writes; index past the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_low_reg  <= TEMP_LOW_RESET;
            temp_high_reg <= TEMP_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_TEMP_LOW)
            begin
                temp_low_reg <= $signed(cfg_wdata);
            end
            if (cfg_index == CFG_TEMP_HIGH)
            begin
                temp_high_reg <= $signed(cfg_wdata);
            end
        end
    end

    // Front end: byte count, word assembly, CRC check
    htfd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (s_tvalid),
        .byte_ready  (s_tready),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser),
        .queue_full  (queue_full),
        .push        (push),
        .frame       (push_frame)
    );

    // Frame queue decoupling the byte side from the result side
    htfd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_frame),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_frame),
        .empty     (queue_empty)
    );

    // Back end: scaling, limit check, output register
    htfd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (!queue_empty),
        .in_ready   (pop),
        .in_frame   (pop_frame),
        .temp_low   (temp_low_reg),
        .temp_high  (temp_high_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {1'b0, result};

    // Humidity never exceeds full scale on a delivered beat
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (result.hum <= HUM_MAX[HUM_W-1:0]))
        else $error("humidity above full scale");

    // Temperature stays within the sensor span
    a_temp_span: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (result.temp >= -15'sd4500) && (result.temp <= 15'sd13000))
        else $error("temperature outside sensor span");

    // An OK status implies the temperature lies inside the limits
    a_ok_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (result.status == STATUS_OK)) |->
            ((result.temp >= temp_low_reg) && (result.temp <= temp_high_reg)))
        else $error("OK status with temperature outside limits");

    // Input backpressure only comes from a full frame queue
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> queue_full && !queue_empty)
        else $error("input stalled without full queue");

endmodule
